/* design/llff_pkg.sv */
package llff_pkg;

  localparam int FLOW_W = 32;
  localparam int RAND_W = 31;
  localparam int CELL_W = 5;
  localparam int SUM_W  = 7;
  localparam int CNT_W  = 32;
  localparam int LANES  = 3;

  // murmur3 x86_32 constants for a single 4-byte block
  localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2 = 32'h1b873593;
  localparam logic [31:0] MUR_N  = 32'he6546b64;
  localparam logic [31:0] MUR_F1 = 32'h85ebca6b;
  localparam logic [31:0] MUR_F2 = 32'hc2b2ae35;
  localparam logic [31:0] MUR_LEN = 32'd4;

  // hash lane step schedule
  localparam logic [5:0] STEP_MOD0 = 6'd5;
  localparam logic [5:0] STEP_LAST = 6'd7;

  typedef logic [CELL_W-1:0] cell_t;

endpackage

/* design/llff_in_if.sv */
interface llff_in_if;
  import llff_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [FLOW_W-1:0] flow_key;
  logic [RAND_W-1:0] rand_a;
  logic [RAND_W-1:0] rand_b;
  logic [RAND_W-1:0] rand_c;

  modport source (output valid, output op, output flow_key, output rand_a,
                  output rand_b, output rand_c, input ready);
  modport sink (input valid, input op, input flow_key, input rand_a,
                input rand_b, input rand_c, output ready);
endinterface

/* design/llff_out_if.sv */
interface llff_out_if;
  import llff_pkg::*;
  logic              valid;
  logic              ready;
  logic              to_sketch;
  logic [CELL_W-1:0] min_cell;
  logic [SUM_W-1:0]  cell_sum;
  logic [CNT_W-1:0]  filtered_total;

  modport source (output valid, output to_sketch, output min_cell, output cell_sum,
                  output filtered_total, input ready);
  modport sink (input valid, input to_sketch, input min_cell, input cell_sum,
                input filtered_total, output ready);
endinterface

/* design/llff_hash_lane.sv */
// One murmur3 hash of a 4-byte key, then a remainder by NUM_CELLS through a
// reciprocal multiply and one corrective subtract.
module llff_hash_lane #(
  parameter int NUM_CELLS = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [31:0]                    key,
  input  logic [31:0]                    seed,
  output logic                           done,
  output logic [$clog2(NUM_CELLS)-1:0]   idx
);
  import llff_pkg::*;

  localparam int IDX_W = $clog2(NUM_CELLS);
  localparam logic [IDX_W:0] MODULUS = (IDX_W+1)'(NUM_CELLS);
  localparam logic [31:0] MOD32 = 32'(NUM_CELLS);
  // floor(2^32 / NUM_CELLS); the estimated quotient is low by at most one
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(NUM_CELLS));

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [5:0]       step_r, step_nxt;
  logic [31:0]      h_r, h_nxt;
  logic [31:0]      q_r, q_nxt;
  logic [IDX_W-1:0] rem_r, rem_nxt;

  logic [31:0] mix;
  logic [31:0] fold;
  logic [63:0] prod;

  always_comb begin
    mix   = seed ^ h_r;
    mix   = {mix[18:0], mix[31:19]};
    mix   = (mix << 2) + mix + MUR_N;
    mix   = mix ^ MUR_LEN;
    mix   = mix ^ (mix >> 16);
    fold  = h_r ^ (h_r >> 13);
    prod  = 64'(h_r) * 64'(RECIP);

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    h_nxt    = h_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
        h_nxt    = 32'(key * MUR_C1);
      end
    end else begin
      step_nxt = step_r + 6'd1;
      case (step_r)
        6'd0: h_nxt = 32'({h_r[16:0], h_r[31:17]} * MUR_C2);
        6'd1: h_nxt = mix;
        6'd2: h_nxt = 32'(h_r * MUR_F1);
        6'd3: h_nxt = 32'(fold * MUR_F2);
        6'd4: h_nxt = h_r ^ (h_r >> 16);
        STEP_MOD0: q_nxt = prod[63:32];
        // partial remainder, below twice the modulus
        6'd6: h_nxt = h_r - 32'(q_r * MOD32);
        STEP_LAST: begin
          if (h_r >= MOD32) begin
            rem_nxt = IDX_W'(h_r - MOD32);
          end else begin
            rem_nxt = IDX_W'(h_r);
          end
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    h_r   <= h_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign idx  = rem_r;

  // the first remainder step must follow the last mixing step
  a_mod_order: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == STEP_MOD0) |-> $past(step_r) == STEP_MOD0 - 6'd1)
    else $error("remainder started out of order");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < MODULUS))
    else $error("cell index not below modulus");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held");

endmodule

/* design/loglog_flow_filter_unit.sv */
// channel   dir  handshake      payload
// in_if     in   valid/ready    op, flow_key, rand_a, rand_b, rand_c
// out_if    out  valid/ready    to_sketch, min_cell, cell_sum, filtered_total
// cfg_*     in   APB, pready=1  seed_a @0, seed_b @4, seed_c @8, threshold @12
//
// Each item passes, in order, through the hash lanes (five mixing steps, three for
// the remainder by reciprocal, one hand-off), NUM_HASHES cell reads, an evaluate
// step, NUM_HASHES cell writes on an absorbed update, a result hand-off and a
// return to idle before the next accept. After reset a clearing pass zeroes the
// cell memory; no item is taken meanwhile, configuration writes are. A result
// waiting on out_if holds back only the hand-off of the next result.
module loglog_flow_filter_unit #(
  parameter int NUM_CELLS  = 65536,
  parameter int NUM_HASHES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  llff_in_if.sink     in_if,
  llff_out_if.source  out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import llff_pkg::*;

  localparam int IDX_W = $clog2(NUM_CELLS);
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(NUM_CELLS - 1);
  localparam logic [1:0] HN      = 2'(NUM_HASHES);
  localparam logic [1:0] LAST_LN = 2'(NUM_HASHES - 1);

  localparam logic [1:0] REG_SEED_A = 2'd0;
  localparam logic [1:0] REG_SEED_B = 2'd1;
  localparam logic [1:0] REG_SEED_C = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // configuration
  logic [31:0] seed_r [LANES];
  logic [4:0]  thr_r;
  logic        cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r[0] <= 32'd0;
      seed_r[1] <= 32'd1;
      seed_r[2] <= 32'd2;
      thr_r     <= 5'd10;
    end else if (cfg_we) begin
      case (cfg_paddr[3:2])
        REG_SEED_A: seed_r[0] <= cfg_pwdata;
        REG_SEED_B: seed_r[1] <= cfg_pwdata;
        REG_SEED_C: seed_r[2] <= cfg_pwdata;
        REG_THRESH: thr_r     <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SEED_A: cfg_prdata = seed_r[0];
      REG_SEED_B: cfg_prdata = seed_r[1];
      REG_SEED_C: cfg_prdata = seed_r[2];
      default:    cfg_prdata = {27'd0, thr_r};
    endcase
  end

  // control and item registers
  logic [2:0]        state_r, state_nxt;
  logic [1:0]        ln_r, ln_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [CNT_W-1:0]  abs_r, abs_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              op_r;
  logic [FLOW_W-1:0] label_r;
  logic [RAND_W-1:0] rand_r [LANES];
  cell_t             cell_r [LANES];
  cell_t             nv_r   [LANES];
  cell_t             nv_c   [LANES];
  logic              absorb_r;
  logic              pass_r;
  cell_t             min_r;
  logic [SUM_W-1:0]  sum_r;

  // hash lanes
  logic             lane_start;
  logic [LANES-1:0] lane_done;
  logic [IDX_W-1:0] idx [LANES];

  assign lane_start = (state_r == S_IDLE) && in_if.valid;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    if (g < NUM_HASHES) begin : g_on
      llff_hash_lane #(.NUM_CELLS(NUM_CELLS)) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .key   (in_if.flow_key),
        .seed  (seed_r[g]),
        .done  (lane_done[g]),
        .idx   (idx[g])
      );
    end else begin : g_off
      assign lane_done[g] = 1'b1;
      assign idx[g]       = '0;
    end
  end

  // cell memory, one write and one registered read port
  cell_t            mem [NUM_CELLS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  cell_t            mem_wd;
  logic [IDX_W-1:0] mem_ra;
  cell_t            mem_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  // evaluate: least, sum and raise values
  cell_t            least;
  logic [SUM_W-1:0] sum;
  logic             absorb;
  logic [5:0]       lz;
  cell_t            lzc [LANES];

  always_comb begin
    least = cell_r[0];
    sum   = '0;
    for (int i = 0; i < NUM_HASHES; i++) begin
      if (cell_r[i] < least) begin
        least = cell_r[i];
      end
      sum = sum + SUM_W'(cell_r[i]);
    end
    absorb = !op_r && (least < thr_r);

    for (int i = 0; i < LANES; i++) begin
      lz = 6'd32;
      for (int b = 0; b < RAND_W; b++) begin
        if (rand_r[i][b]) begin
          lz = 6'(31 - b);
        end
      end
      lzc[i] = (lz > {1'b0, thr_r}) ? thr_r : lz[4:0];
    end

    // a cell picked by several lanes takes the largest raise of them all
    for (int i = 0; i < LANES; i++) begin
      nv_c[i] = cell_r[i];
      for (int j = 0; j < NUM_HASHES; j++) begin
        if (idx[j] == idx[i] && lzc[j] > nv_c[i]) begin
          nv_c[i] = lzc[j];
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ln_nxt        = ln_r;
    clr_nxt       = clr_r;
    abs_nxt       = abs_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_wa        = idx[ln_r];
    mem_wd        = nv_r[ln_r];
    mem_ra        = idx[0];

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_if.valid) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        ln_nxt = '0;
        if (&lane_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (ln_r < HN) begin
          mem_ra = idx[ln_r];
        end
        ln_nxt = ln_r + 2'd1;
        if (ln_r == HN) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        ln_nxt = '0;
        if (absorb) begin
          abs_nxt = abs_r + 1'b1;
        end
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        mem_we = absorb_r;
        ln_nxt = ln_r + 2'd1;
        if (ln_r == LAST_LN) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ln_r        <= '0;
      clr_r       <= '0;
      abs_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ln_r        <= ln_nxt;
      clr_r       <= clr_nxt;
      abs_r       <= abs_nxt;
      out_valid_r <= out_valid_nxt;
    end

    if (lane_start) begin
      op_r      <= in_if.op;
      label_r   <= in_if.flow_key;
      rand_r[0] <= in_if.rand_a;
      rand_r[1] <= in_if.rand_b;
      rand_r[2] <= in_if.rand_c;
    end
    // read data for the lane addressed in the previous cycle
    if (state_r == S_READ && ln_r != 2'd0) begin
      cell_r[ln_r - 2'd1] <= mem_q;
    end
    if (state_r == S_EVAL) begin
      absorb_r <= absorb;
      pass_r   <= (least >= thr_r);
      min_r    <= least;
      sum_r    <= sum;
      nv_r     <= nv_c;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_if.ready)) begin
      out_if.to_sketch      <= pass_r;
      out_if.min_cell       <= min_r;
      out_if.cell_sum       <= sum_r;
      out_if.filtered_total <= abs_r;
    end
  end

  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = out_valid_r;

  a_no_wr_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !mem_we)
    else $error("cell write during read phase");
  a_wr_only_absorb: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_CLEAR) |-> (state_r == S_WRITE && absorb_r && !op_r))
    else $error("cell write without absorbed update");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (abs_r != $past(abs_r)) |-> ($past(state_r) == S_EVAL && $past(absorb)))
    else $error("absorbed count moved outside evaluate");
  a_lanes_done: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done[0] && NUM_HASHES > 0) |-> (state_r == S_HASH) && (label_r == $past(label_r)))
    else $error("hash finished outside hash phase");

endmodule

/* tb/sv/tb.sv */
module tb;
  import llff_pkg::*;

  localparam int N_CELLS = 65536;
  localparam int ADDR_SEED_A = 0;
  localparam int ADDR_SEED_B = 4;
  localparam int ADDR_SEED_C = 8;
  localparam int ADDR_THRESH = 12;
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic              to_sketch;
    logic [CELL_W-1:0] min_cell;
    logic [SUM_W-1:0]  cell_sum;
    logic [CNT_W-1:0]  filtered_total;
  } flow_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  llff_in_if  in_if ();
  llff_out_if out_if ();

  loglog_flow_filter_unit dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [CELL_W-1:0] cell_mem [N_CELLS];
  logic [31:0] absorbed;
  logic [31:0] seed_a_q, seed_b_q, seed_c_q;
  logic [4:0]  thresh_q;

  flow_result_t expected_q[$];
  int errors = 0;
  bit idle_en = 1'b1;
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.op = 1'b0;
    in_if.flow_key = '0;
    in_if.rand_a = '0;
    in_if.rand_b = '0;
    in_if.rand_c = '0;
    out_if.ready = 1'b0;
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] murmur4(logic [31:0] key, logic [31:0] seed);
    logic [31:0] k, h;
    k = key * 32'hcc9e2d51;
    k = rotl(k, 15);
    k = k * 32'h1b873593;
    h = seed ^ k;
    h = rotl(h, 13);
    h = h * 32'd5 + 32'he6546b64;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic int clz31(logic [30:0] r);
    int n;
    n = 32;
    for (int i = 0; i < 31; i++)
      if (r[i]) n = 31 - i;
    return n;
  endfunction

  function automatic flow_result_t filter_predict(logic op, logic [31:0] label,
                                                  logic [30:0] ra, logic [30:0] rb,
                                                  logic [30:0] rc);
    flow_result_t res;
    logic [15:0] idx [3];
    logic [30:0] rnd [3];
    int least, sum, lz;
    rnd[0] = ra; rnd[1] = rb; rnd[2] = rc;
    idx[0] = 16'(murmur4(label, seed_a_q) % N_CELLS);
    idx[1] = 16'(murmur4(label, seed_b_q) % N_CELLS);
    idx[2] = 16'(murmur4(label, seed_c_q) % N_CELLS);
    least = 32'hffff;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (cell_mem[idx[i]] < least) least = int'(cell_mem[idx[i]]);
      sum += int'(cell_mem[idx[i]]);
    end
    if (op == OP_UPDATE) begin
      if (least < thresh_q) begin
        res.to_sketch = 1'b0;
        absorbed++;
        for (int i = 0; i < 3; i++) begin
          lz = clz31(rnd[i]);
          if (lz > thresh_q) lz = thresh_q;
          if (lz > cell_mem[idx[i]]) cell_mem[idx[i]] = 5'(lz);
        end
      end else begin
        res.to_sketch = 1'b1;
      end
    end else begin
      res.to_sketch = (least >= thresh_q);
    end
    res.min_cell = least[4:0];
    res.cell_sum = sum[6:0];
    res.filtered_total = absorbed;
    return res;
  endfunction

  task automatic random_gap();
    if (idle_en && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 11)) @(negedge clk);
  endtask

  task automatic send_item(logic op, logic [31:0] label, logic [30:0] ra,
                           logic [30:0] rb, logic [30:0] rc);
    random_gap();
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.op = op;
    in_if.flow_key = label;
    in_if.rand_a = ra;
    in_if.rand_b = rb;
    in_if.rand_c = rc;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_q = {expected_q, filter_predict(op, label, ra, rb, rc)};
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic cfg_write(int addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = 4'(addr); cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (addr)
      ADDR_SEED_A: seed_a_q = data;
      ADDR_SEED_B: seed_b_q = data;
      ADDR_SEED_C: seed_c_q = data;
      ADDR_THRESH: thresh_q = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [30:0] rand_word();
    // spread the leading-zero count evenly, zero now and then
    int lz;
    lz = $urandom_range(0, 31);
    if (lz == 31) return '0;
    return (31'h40000000 >> lz) | (31'($urandom) & ((31'h40000000 >> lz) - 1));
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_req != hold_seen) begin
      out_if.ready <= 1'b0;
      hold_cycles <= 399;
      hold_seen <= hold_req;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= $urandom_range(1, 11) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    flow_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_if.to_sketch !== exp_r.to_sketch) begin
          $error("to_sketch exp %0d got %0d", exp_r.to_sketch, out_if.to_sketch);
          errors++;
        end
        if (out_if.min_cell !== exp_r.min_cell) begin
          $error("min_cell exp %0d got %0d", exp_r.min_cell, out_if.min_cell);
          errors++;
        end
        if (out_if.cell_sum !== exp_r.cell_sum) begin
          $error("cell_sum exp %0d got %0d", exp_r.cell_sum, out_if.cell_sum);
          errors++;
        end
        if (out_if.filtered_total !== exp_r.filtered_total) begin
          $error("filtered_total exp %0d got %0d", exp_r.filtered_total,
                 out_if.filtered_total);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(OP_QUERY, 32'h0, 31'h0, 31'h0, 31'h0);
    send_item(OP_UPDATE, 32'h0, 31'h0, 31'h0, 31'h0);
    send_item(OP_QUERY, 32'h0, 31'h0, 31'h0, 31'h0);
    send_item(OP_UPDATE, 32'hffffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send_item(OP_UPDATE, 32'hffffffff, 31'h1, 31'h2, 31'h4);
    send_item(OP_QUERY, 32'hffffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    for (int i = 0; i < 6; i++)
      send_item(OP_UPDATE, 32'h12345678, 31'h0, 31'h0, 31'h0);
    send_item(OP_QUERY, 32'h12345678, 31'h0, 31'h0, 31'h0);
    send_item(OP_UPDATE, 32'h80000000, 31'h40000000, 31'h00010000, 31'h0);
    drain();
    // lowered threshold: saturated cells exceed it
    cfg_write(ADDR_THRESH, 32'd1);
    send_item(OP_QUERY, 32'h12345678, 31'h0, 31'h0, 31'h0);
    send_item(OP_UPDATE, 32'h12345678, 31'h0, 31'h0, 31'h0);
    send_item(OP_UPDATE, 32'h55555555, 31'h0, 31'h0, 31'h0);
    send_item(OP_UPDATE, 32'h55555555, 31'h0, 31'h0, 31'h0);
    drain();
    // all seeds equal: one cell picked three times
    cfg_write(ADDR_THRESH, 32'd31);
    cfg_write(ADDR_SEED_A, 32'h0);
    cfg_write(ADDR_SEED_B, 32'h0);
    cfg_write(ADDR_SEED_C, 32'h0);
    send_item(OP_UPDATE, 32'haaaaaaaa, 31'h00100000, 31'h0, 31'h00000100);
    send_item(OP_QUERY, 32'haaaaaaaa, 31'h0, 31'h0, 31'h0);
    drain();
  endtask

  task automatic run_random(int count, int flows);
    logic [31:0] pool [16];
    logic [31:0] lbl;
    for (int i = 0; i < 16; i++) pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      lbl = ($urandom_range(0, 3) == 0) ? $urandom
                                        : pool[4'($urandom_range(0, flows - 1))];
      send_item($urandom_range(0, 3) == 0 ? OP_QUERY : OP_UPDATE, lbl,
                rand_word(), rand_word(), rand_word());
    end
  endtask

  task automatic test_random_settings();
    cfg_write(ADDR_SEED_A, 32'hffffffff);
    cfg_write(ADDR_SEED_B, $urandom);
    cfg_write(ADDR_SEED_C, 32'h9e3779b9);
    cfg_write(ADDR_THRESH, 32'd10);
    run_random(400, 16);
    drain();
    cfg_write(ADDR_THRESH, 32'd3);
    cfg_write(ADDR_SEED_B, 32'hffffffff);
    run_random(300, 8);
    drain();
    cfg_write(ADDR_THRESH, 32'd0);
    run_random(100, 8);
    drain();
    cfg_write(ADDR_THRESH, 32'd31);
    cfg_write(ADDR_SEED_A, $urandom);
    run_random(300, 16);
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        @(negedge clk);
        hold_req++;
      end
      run_random(20, 4);
    join
    drain();
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    cfg_write(ADDR_THRESH, 32'd12);
    run_random(350, 16);
    drain();
  endtask

  initial begin
    seed_a_q = 32'd0;
    seed_b_q = 32'd1;
    seed_c_q = 32'd2;
    thresh_q = 5'd10;
    absorbed = '0;
    for (int i = 0; i < N_CELLS; i++) cell_mem[i] = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_settings();
    test_backpressure();
    test_no_idle();
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #12000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
design/llff_pkg.sv
design/llff_in_if.sv
design/llff_out_if.sv
design/llff_hash_lane.sv
design/loglog_flow_filter_unit.sv
tb/sv/tb.sv
